[hdl/urx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urx_pkg
// Shared constants, codes and types of the UART frame receiver.
// ----------------------------------------------------------------------------
package urx_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // Request operations.
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_GET  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FRAME_MODE     = 3'd0;
  localparam logic [2:0] CFG_START_REQUIRED = 3'd1;
  localparam logic [2:0] CFG_START_BYTE     = 3'd2;
  localparam logic [2:0] CFG_STOP_BYTE      = 3'd3;
  localparam logic [2:0] CFG_SILENCE_TICKS  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RECV  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_STREAM = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic accept;  // a request is taken this cycle
    logic stream;  // issue one buffer read of a get
  } urx_cmd_t;

  typedef struct packed {
    logic stream_go;   // the offered request is a get that hands out bytes
    logic issue_last;  // the read issued this cycle is the final one
  } urx_sts_t;

endpackage

[hdl/urx_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urx_ctrl
// Controller: accepts requests and sequences the byte stream of a get.
// ----------------------------------------------------------------------------
module urx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  urx_pkg::urx_sts_t sts,
  output urx_pkg::urx_cmd_t cmd
);

  urx_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= urx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b0;
    cmd.accept = 1'b0;
    cmd.stream = 1'b0;
    case (state_r)
      urx_pkg::ST_IDLE: begin
        cmd.accept = start;
        if (start && sts.stream_go) begin
          state_nxt = urx_pkg::ST_STREAM;
        end
      end
      urx_pkg::ST_STREAM: begin
        busy       = 1'b1;
        cmd.stream = 1'b1;
        if (sts.issue_last) begin
          state_nxt = urx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = urx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/urx_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urx_datapath
// Datapath: configuration registers, framing state, frame buffer and the
// registered result stage.
// ----------------------------------------------------------------------------
module urx_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  urx_pkg::urx_cmd_t          cmd,
  output urx_pkg::urx_sts_t          sts,
  input  logic [1:0]                 in_operation,
  input  logic [7:0]                 in_rx_byte,
  input  logic [7:0]                 in_max_len,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  output logic                       out_valid,
  output logic                       out_has_data,
  output logic [7:0]                 out_data_byte,
  output logic [4:0]                 out_byte_index,
  output logic [5:0]                 out_copied_count,
  output logic                       out_last,
  output logic                       out_frame_ready,
  output logic [5:0]                 out_frame_length
);

  localparam int AW = urx_pkg::ADDR_W;
  localparam int CW = urx_pkg::CNT_W;

  // Configuration.
  logic        mode_r, start_req_r;
  logic [7:0]  start_byte_r, stop_byte_r;
  logic [15:0] silence_ticks_r;

  // Framing state.
  urx_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [15:0]     silence_r, silence_nxt;

  // Frame buffer.
  logic [7:0]    mem [urx_pkg::BUF_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data_r;

  // Get sequencing.
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] get_n;

  // Result stage.
  logic          valid_r, has_r, last_r, ready_r;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] copied_r, olen_r;

  logic          append_room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= 1'b0;
      start_req_r     <= 1'b1;
      start_byte_r    <= 8'd2;
      stop_byte_r     <= 8'd3;
      silence_ticks_r <= 16'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        urx_pkg::CFG_FRAME_MODE:     mode_r          <= cfg_data[0];
        urx_pkg::CFG_START_REQUIRED: start_req_r     <= cfg_data[0];
        urx_pkg::CFG_START_BYTE:     start_byte_r    <= cfg_data[7:0];
        urx_pkg::CFG_STOP_BYTE:      stop_byte_r     <= cfg_data[7:0];
        urx_pkg::CFG_SILENCE_TICKS:  silence_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bytes handed out by a get: the smaller of stored count and max_len.
  assign get_n = ({{(8 - CW){1'b0}}, count_r} < in_max_len) ? count_r
                                                             : in_max_len[CW-1:0];

  assign sts.stream_go  = (in_operation == urx_pkg::OP_GET) &&
                          (phase_r == urx_pkg::PH_READY) && (get_n != '0);
  assign sts.issue_last = cmd.stream &&
                          ({{(CW - AW){1'b0}}, rd_idx_r} == len_r - CW'(1));

  assign append_room = (count_r < CW'(urx_pkg::BUF_DEPTH));

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    silence_nxt = silence_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[AW-1:0];
    len_nxt     = len_r;
    rd_idx_nxt  = rd_idx_r;
    if (cmd.stream) begin
      rd_idx_nxt = rd_idx_r + AW'(1);
    end
    if (cmd.accept) begin
      case (in_operation)
        urx_pkg::OP_BYTE: begin
          if (phase_r != urx_pkg::PH_READY) begin
            if (!mode_r) begin
              if (phase_r == urx_pkg::PH_IDLE) begin
                if (start_req_r) begin
                  if (in_rx_byte == start_byte_r) begin
                    count_nxt = '0;
                    phase_nxt = urx_pkg::PH_RECV;
                  end
                end else begin
                  wr_en     = 1'b1;
                  wr_addr   = '0;
                  count_nxt = CW'(1);
                  phase_nxt = urx_pkg::PH_RECV;
                end
              end else if (in_rx_byte == stop_byte_r) begin
                phase_nxt = urx_pkg::PH_READY;
              end else if (append_room) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                phase_nxt = urx_pkg::PH_READY;
              end
            end else begin
              silence_nxt = silence_ticks_r;
              if (phase_r == urx_pkg::PH_IDLE) begin
                // A new frame starts empty, so the byte lands in entry zero.
                wr_en     = 1'b1;
                wr_addr   = '0;
                count_nxt = CW'(1);
                phase_nxt = urx_pkg::PH_RECV;
              end else if (append_room) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                phase_nxt = urx_pkg::PH_READY;
              end
            end
          end
        end
        urx_pkg::OP_TICK: begin
          if (mode_r && (phase_r == urx_pkg::PH_RECV) && (silence_r != '0)) begin
            silence_nxt = silence_r - 16'd1;
            if (silence_r == 16'd1) begin
              phase_nxt = urx_pkg::PH_READY;
            end
          end
        end
        urx_pkg::OP_GET: begin
          if (phase_r == urx_pkg::PH_READY) begin
            phase_nxt  = urx_pkg::PH_IDLE;
            count_nxt  = '0;
            len_nxt    = get_n;
            rd_idx_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= urx_pkg::PH_IDLE;
      count_r   <= '0;
      silence_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      silence_r <= silence_nxt;
      valid_r   <= (cmd.accept && !sts.stream_go) || cmd.stream;
    end
  end

  // Result fields: a stream read fills a data result, any other request a
  // status result. Frame status always reflects the state after the request.
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    len_r    <= len_nxt;
    has_r    <= cmd.stream;
    idx_r    <= cmd.stream ? rd_idx_r : '0;
    copied_r <= cmd.stream ? len_r : '0;
    last_r   <= cmd.stream ? sts.issue_last : 1'b1;
    ready_r  <= (phase_nxt == urx_pkg::PH_READY);
    olen_r   <= count_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_rx_byte;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  assign out_valid        = valid_r;
  assign out_has_data     = has_r;
  assign out_data_byte    = has_r ? rd_data_r : 8'd0;
  assign out_byte_index   = 5'(idx_r);
  assign out_copied_count = 6'(copied_r);
  assign out_last         = last_r;
  assign out_frame_ready  = ready_r;
  assign out_frame_length = 6'(olen_r);

endmodule

[hdl/uart_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_receiver_core
// Collects received UART bytes into frames, closed by a stop byte or by a
// silence timeout, and hands a finished frame out one byte per cycle.
// ----------------------------------------------------------------------------
// Each request (received byte, millisecond tick or get) is taken when start is
// high and busy is low. A byte, a tick, or a get that finds no ready frame or
// hands out no bytes (empty frame or max_len zero) produces one status result,
// strobed on out_valid in the cycle after the request; while busy is low a new
// request can be taken every cycle. A get of n bytes holds busy while the
// controller walks the frame buffer through its single registered read port,
// and the n results appear on consecutive cycles. There is no back-pressure on
// the result side: every strobed result must be captured in its cycle.
// Configuration writes are always accepted (cfg_ready is tied high).
module uart_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_max_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic        out_has_data,
  output logic [7:0]  out_data_byte,
  output logic [4:0]  out_byte_index,
  output logic [5:0]  out_copied_count,
  output logic        out_last,
  output logic        out_frame_ready,
  output logic [5:0]  out_frame_length
);

  urx_pkg::urx_cmd_t cmd;
  urx_pkg::urx_sts_t sts;

  urx_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  urx_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_rx_byte       (in_rx_byte),
    .in_max_len       (in_max_len),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_has_data     (out_has_data),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_copied_count (out_copied_count),
    .out_last         (out_last),
    .out_frame_ready  (out_frame_ready),
    .out_frame_length (out_frame_length)
  );

endmodule

[dv/urx_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urx_frame_checker
// Watches the request, result and configuration channels of the UART frame
// receiver, keeps its own copy of the framing state, predicts every result
// and compares the strobed results with the predictions in order.
// ----------------------------------------------------------------------------
module urx_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_max_len,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_has_data,
  input  logic [7:0]  out_data_byte,
  input  logic [4:0]  out_byte_index,
  input  logic [5:0]  out_copied_count,
  input  logic        out_last,
  input  logic        out_frame_ready,
  input  logic [5:0]  out_frame_length,
  output int          n_awaited,
  output int          n_mismatch
);

  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic [5:0] copied;
    logic       last;
    logic       frame_ready;
    logic [5:0] frame_length;
  } frame_result_t;

  frame_result_t awaited_results[$];

  // Framing settings as last written.
  logic        mode_timeout;
  logic        need_start;
  logic [7:0]  open_byte;
  logic [7:0]  close_byte;
  logic [15:0] quiet_limit;

  // Framing state.
  urx_pkg::phase_t rx_phase;
  logic [7:0]      frame_buf [urx_pkg::BUF_DEPTH];
  logic [5:0]      frame_len;
  logic [15:0]     quiet_cnt;

  initial begin
    n_awaited  = 0;
    n_mismatch = 0;
  end

  function automatic frame_result_t status_result();
    frame_result_t r;
    r              = '0;
    r.last         = 1'b1;
    r.frame_ready  = (rx_phase == urx_pkg::PH_READY);
    r.frame_length = frame_len;
    return r;
  endfunction

  // Stores a byte in the frame, or closes the frame when the buffer is full.
  task automatic store_or_close(input logic [7:0] b);
    if (frame_len < urx_pkg::BUF_DEPTH) begin
      frame_buf[frame_len[4:0]] = b;
      frame_len = frame_len + 6'd1;
    end else begin
      rx_phase = urx_pkg::PH_READY;
    end
  endtask

  task automatic apply_request(input logic [1:0] op, input logic [7:0] b,
                               input logic [7:0] ml);
    frame_result_t r;
    int n;
    n = 0;
    if (op == urx_pkg::OP_BYTE) begin
      if (rx_phase != urx_pkg::PH_READY) begin
        if (!mode_timeout) begin
          if (rx_phase == urx_pkg::PH_IDLE) begin
            if (!need_start) begin
              frame_buf[0] = b;
              frame_len    = 6'd1;
              rx_phase     = urx_pkg::PH_RECV;
            end else if (b == open_byte) begin
              frame_len = 6'd0;
              rx_phase  = urx_pkg::PH_RECV;
            end
          end else if (b == close_byte) begin
            rx_phase = urx_pkg::PH_READY;
          end else begin
            store_or_close(b);
          end
        end else begin
          quiet_cnt = quiet_limit;
          if (rx_phase == urx_pkg::PH_IDLE) begin
            frame_len = 6'd0;
            rx_phase  = urx_pkg::PH_RECV;
          end
          store_or_close(b);
        end
      end
    end else if (op == urx_pkg::OP_TICK) begin
      if (mode_timeout && rx_phase == urx_pkg::PH_RECV && quiet_cnt != 16'd0) begin
        quiet_cnt = quiet_cnt - 16'd1;
        if (quiet_cnt == 16'd0) rx_phase = urx_pkg::PH_READY;
      end
    end else if (op == urx_pkg::OP_GET && rx_phase == urx_pkg::PH_READY) begin
      n = (int'(frame_len) < int'(ml)) ? int'(frame_len) : int'(ml);
      frame_len = 6'd0;
      rx_phase  = urx_pkg::PH_IDLE;
      // The buffer itself is left untouched, so it can be read after release.
      for (int i = 0; i < n; i++) begin
        r              = '0;
        r.has_data     = 1'b1;
        r.data_byte    = frame_buf[i];
        r.byte_index   = 5'(i);
        r.copied       = 6'(n);
        r.last         = (i == n - 1);
        awaited_results.push_back(r);
      end
    end
    if (n == 0) awaited_results.push_back(status_result());
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      mode_timeout = 1'b0;
      need_start   = 1'b1;
      open_byte    = 8'd2;
      close_byte   = 8'd3;
      quiet_limit  = 16'd10;
      rx_phase     = urx_pkg::PH_IDLE;
      frame_len    = 6'd0;
      quiet_cnt    = 16'd0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          urx_pkg::CFG_FRAME_MODE:     mode_timeout = cfg_data[0];
          urx_pkg::CFG_START_REQUIRED: need_start   = cfg_data[0];
          urx_pkg::CFG_START_BYTE:     open_byte    = cfg_data[7:0];
          urx_pkg::CFG_STOP_BYTE:      close_byte   = cfg_data[7:0];
          urx_pkg::CFG_SILENCE_TICKS:  quiet_limit  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        got = '{out_has_data, out_data_byte, out_byte_index, out_copied_count,
                out_last, out_frame_ready, out_frame_length};
        if (awaited_results.size() == 0) begin
          n_mismatch = n_mismatch + 1;
          if (n_mismatch <= 10)
            $display("%0t: result with nothing awaited: has=%0d data=%02h idx=%0d",
                     $realtime, got.has_data, got.data_byte, got.byte_index);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            n_mismatch = n_mismatch + 1;
            if (n_mismatch <= 10) begin
              $display("%0t: mismatch expected has=%0d data=%02h idx=%0d copied=%0d last=%0d",
                       $realtime, want.has_data, want.data_byte, want.byte_index,
                       want.copied, want.last);
              $display("  expected ready=%0d len=%0d, got has=%0d data=%02h idx=%0d",
                       want.frame_ready, want.frame_length, got.has_data,
                       got.data_byte, got.byte_index);
              $display("  got copied=%0d last=%0d ready=%0d len=%0d",
                       got.copied, got.last, got.frame_ready, got.frame_length);
            end
          end
        end
      end
      if (start && !busy) apply_request(in_operation, in_rx_byte, in_max_len);
    end
    n_awaited = awaited_results.size();
  end

endmodule

[dv/tb_uart_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_frame_receiver_core
// Drives received bytes, millisecond ticks and get requests into the frame
// receiver under several framing settings: a directed opening, then framed
// sequences with random content mixed with noise and random sender gaps.
// ----------------------------------------------------------------------------
module tb_uart_frame_receiver_core;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         PHASE_ITEMS  = 30;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [7:0]  in_rx_byte;
  logic [7:0]  in_max_len;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic        out_has_data;
  logic [7:0]  out_data_byte;
  logic [4:0]  out_byte_index;
  logic [5:0]  out_copied_count;
  logic        out_last;
  logic        out_frame_ready;
  logic [5:0]  out_frame_length;

  int n_awaited;
  int n_mismatch;
  int cycle_cnt;
  int items_sent;
  bit gaps_on;

  // Settings as written, used to shape well-formed frames.
  logic        cur_mode;
  logic        cur_need;
  logic [7:0]  cur_open;
  logic [7:0]  cur_close;
  logic [15:0] cur_quiet;

  uart_frame_receiver_core u_top (.*);

  urx_frame_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("uart_frame_receiver_core test failed");
      $finish;
    end
  end

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      start        <= 1'b0;
      in_operation <= 2'($urandom);
      in_rx_byte   <= 8'($urandom);
      in_max_len   <= 8'($urandom);
    end
  endtask

  // Offers one request and returns once it has been taken; start stays high.
  task automatic issue(input logic [1:0] op, input logic [7:0] b, input logic [7:0] ml);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 16));
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= b;
    in_max_len   <= ml;
    items_sent++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (n_awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input logic mode, input logic need, input logic [7:0] open_b,
                       input logic [7:0] close_b, input logic [15:0] quiet);
    drain();
    write_reg(urx_pkg::CFG_FRAME_MODE, 16'(mode));
    write_reg(urx_pkg::CFG_START_REQUIRED, 16'(need));
    write_reg(urx_pkg::CFG_START_BYTE, 16'(open_b));
    write_reg(urx_pkg::CFG_STOP_BYTE, 16'(close_b));
    write_reg(urx_pkg::CFG_SILENCE_TICKS, quiet);
    cur_mode  = mode;
    cur_need  = need;
    cur_open  = open_b;
    cur_close = close_b;
    cur_quiet = quiet;
  endtask

  // One well-formed frame under the current settings, followed by a get.
  task automatic send_frame();
    int k;
    logic [7:0] b;
    logic [7:0] ml;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 8);
    // Without a usable timeout only a full buffer closes the frame.
    if (cur_mode && (cur_quiet == 16'd0 || cur_quiet > 16'd16)) k = $urandom_range(33, 34);
    if (!cur_mode && cur_need) issue(urx_pkg::OP_BYTE, cur_open, 8'($urandom));
    for (int i = 0; i < k; i++) begin
      b = 8'($urandom);
      if (!cur_mode && b == cur_close) b = b ^ 8'h01;
      issue(urx_pkg::OP_BYTE, b, 8'($urandom));
      if (cur_mode && cur_quiet > 16'd1 && cur_quiet <= 16'd16
          && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, cur_quiet - 1))
          issue(urx_pkg::OP_TICK, 8'($urandom), 8'($urandom));
      end else if (!cur_mode && $urandom_range(0, 7) == 0) begin
        issue(urx_pkg::OP_TICK, 8'($urandom), 8'($urandom));
      end
    end
    if (!cur_mode)
      issue(urx_pkg::OP_BYTE, cur_close, 8'($urandom));
    else if (cur_quiet != 16'd0 && cur_quiet <= 16'd16)
      repeat (cur_quiet + $urandom_range(0, 1))
        issue(urx_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    case ($urandom_range(0, 4))
      0:       ml = 8'd0;
      1:       ml = 8'hFF;
      2:       ml = 8'($urandom_range(0, k));
      default: ml = 8'($urandom_range(k, 40));
    endcase
    issue(urx_pkg::OP_GET, 8'($urandom), ml);
  endtask

  initial begin
    logic [7:0] ob;
    cycle_cnt    = 0;
    items_sent   = 0;
    gaps_on      = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = urx_pkg::OP_BYTE;
    in_rx_byte   = 8'd0;
    in_max_len   = 8'd0;
    cfg_valid    = 1'b0;
    cfg_index    = urx_pkg::CFG_FRAME_MODE;
    cfg_data     = 16'd0;
    cur_mode     = 1'b0;
    cur_need     = 1'b1;
    cur_open     = 8'd2;
    cur_close    = 8'd3;
    cur_quiet    = 16'd10;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Settings after reset: a start byte of 2 opens, a stop byte of 3 closes.
    issue(urx_pkg::OP_GET, 8'h00, 8'hFF);
    issue(urx_pkg::OP_TICK, 8'h00, 8'h00);
    issue(OP_UNUSED, 8'hFF, 8'hFF);
    issue(urx_pkg::OP_BYTE, 8'h00, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h02, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h00, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'hFF, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h02, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h03, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h55, 8'h00);
    issue(urx_pkg::OP_TICK, 8'h00, 8'h00);
    issue(urx_pkg::OP_GET, 8'h00, 8'd2);
    issue(urx_pkg::OP_BYTE, 8'h02, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h03, 8'h00);
    issue(urx_pkg::OP_GET, 8'h00, 8'hFF);
    issue(urx_pkg::OP_BYTE, 8'h02, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h81, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h03, 8'h00);
    issue(urx_pkg::OP_GET, 8'h00, 8'h00);

    // Silence framing: a byte reloads the count, the second quiet tick closes.
    setup(1'b1, 1'b1, 8'h02, 8'h03, 16'd2);
    issue(urx_pkg::OP_BYTE, 8'hA5, 8'h00);
    issue(urx_pkg::OP_TICK, 8'h00, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h5A, 8'h00);
    issue(urx_pkg::OP_TICK, 8'h00, 8'h00);
    issue(urx_pkg::OP_TICK, 8'h00, 8'h00);
    issue(urx_pkg::OP_GET, 8'h00, 8'hFF);

    // A frame opened by silence framing is finished under delimiter framing.
    issue(urx_pkg::OP_BYTE, 8'h11, 8'h00);
    setup(1'b0, 1'b1, 8'h02, 8'h03, 16'd10);
    issue(urx_pkg::OP_BYTE, 8'h22, 8'h00);
    issue(urx_pkg::OP_BYTE, 8'h03, 8'h00);
    issue(urx_pkg::OP_GET, 8'h00, 8'hFF);

    for (int p = 0; p < 8; p++) begin
      ob = 8'($urandom);
      case (p)
        0: setup(1'b0, 1'b1, 8'h00, 8'hFF, 16'd10);
        1: setup(1'b0, 1'b0, 8'hFF, 8'h00, 16'd10);
        2: setup(1'b1, 1'($urandom), ob, 8'($urandom), 16'd0);
        3: setup(1'b1, 1'($urandom), ob, 8'($urandom), 16'd1);
        4: setup(1'b1, 1'($urandom), ob, 8'($urandom), 16'hFFFF);
        5: setup(1'b0, 1'b1, ob, ob ^ 8'($urandom_range(1, 255)), 16'($urandom));
        6: setup(1'b1, 1'($urandom), ob, 8'($urandom), 16'($urandom_range(2, 6)));
        default: setup(1'($urandom), 1'($urandom), ob, ob ^ 8'($urandom_range(1, 255)),
                       16'($urandom_range(1, 4)));
      endcase
      // The last stretch runs without sender gaps.
      gaps_on = (p != 7);
      for (int n = 0; n < PHASE_ITEMS; n = n) begin
        if ($urandom_range(0, 6) == 0) begin
          issue(2'($urandom), 8'($urandom), 8'($urandom));
          n++;
        end else begin
          n = n - items_sent;
          send_frame();
          n = n + items_sent;
        end
        if (gaps_on && $urandom_range(0, 11) == 0) drain();
      end
    end

    idle_for(1);
    while (n_awaited != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_mismatch == 0)
      $display("uart_frame_receiver_core test passed");
    else
      $display("uart_frame_receiver_core test failed");
    $finish;
  end

endmodule
